@@ sv/rbc_pkg.sv @@
`timescale 1ns / 1ps

package rbc_pkg;

    // Defaults for the top-level parameters
    localparam int DELAY_BITS_DEF   = 24;
    localparam int ATTEMPT_BITS_DEF = 8;

    // Field widths
    localparam int MODE_W    = 2;
    localparam int TIME_W    = 24;
    localparam int RAND_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int ATT_OUT_W = 8;
    localparam int POLICY_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Datapath widths
    localparam int GROWTH_W = 32;
    localparam int FIB_W    = 24;
    localparam int BASE_W   = 33;
    localparam int TERM_W   = 48;
    localparam int MAG_W    = 64;
    localparam int MUL_A_W  = 48;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int STEP_W   = 3;

    localparam logic [GROWTH_W-1:0] Q16_ONE   = 32'h0001_0000;
    localparam logic [MUL_B_W-1:0]  RAND_ONE  = 17'h1_0000;
    localparam logic [FIB_W-1:0]    FIB_ONE   = 24'd1;

    // Register reset values
    localparam logic [1:0]  POLICY_RST     = 2'd2;
    localparam logic [15:0] INIT_DELAY_RST = 16'd1000;
    localparam logic [15:0] MULT_RST       = 16'd512;
    localparam logic [7:0]  MAX_ATT_RST    = 8'd3;
    localparam logic [23:0] MAX_DELAY_RST  = 24'd30000;
    localparam logic [23:0] TIMEOUT_RST    = 24'd0;
    localparam logic [15:0] JITTER_RST     = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY     = 3'd0,
        CFG_INIT_DELAY = 3'd1,
        CFG_MULT       = 3'd2,
        CFG_MAX_ATT    = 3'd3,
        CFG_MAX_DELAY  = 3'd4,
        CFG_TIMEOUT    = 3'd5,
        CFG_JITTER     = 3'd6
    } cfg_idx_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_NONE   = 2'd0,
        POL_LINEAR = 2'd1,
        POL_EXP    = 2'd2,
        POL_FIB    = 2'd3
    } policy_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_RESET  = 2'd0,
        MODE_START  = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_CANCEL = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE      = 3'd0,
        ST_RETRY     = 3'd1,
        ST_SUCCESS   = 3'd2,
        ST_TIMEOUT   = 3'd3,
        ST_MAX_ATT   = 3'd4,
        ST_NO_RETRY  = 3'd5,
        ST_CANCELLED = 3'd6,
        ST_IGNORED   = 3'd7
    } status_t;

    // Microcode fields
    typedef enum logic [2:0] {
        OP_DECIDE, OP_BASE, OP_GROWTH, OP_TERM, OP_MAG, OP_APPLY, OP_CLAMP, OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        A_SCHED, A_GROWTH, A_BASE, A_TERM
    } a_sel_t;

    typedef enum logic [1:0] {
        B_INIT, B_MULT, B_JITTER, B_OFFSET
    } b_sel_t;

    typedef enum logic [1:0] {
        C_NEXT, C_NORETRY, C_NOJITTER, C_FINISH
    } cond_t;

    typedef struct packed {
        op_t                op;
        a_sel_t             a_sel;
        b_sel_t             b_sel;
        cond_t              cond;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_CLAMP = 3'd6;
    localparam logic [STEP_W-1:0] STEP_OUT   = 3'd7;
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;

    function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        case (step)
            3'd0:    w = '{OP_DECIDE, A_GROWTH, B_INIT,   C_NORETRY,  STEP_OUT};
            3'd1:    w = '{OP_BASE,   A_SCHED,  B_INIT,   C_NEXT,     STEP_FIRST};
            3'd2:    w = '{OP_GROWTH, A_GROWTH, B_MULT,   C_NOJITTER, STEP_CLAMP};
            3'd3:    w = '{OP_TERM,   A_BASE,   B_JITTER, C_NEXT,     STEP_FIRST};
            3'd4:    w = '{OP_MAG,    A_TERM,   B_OFFSET, C_NEXT,     STEP_FIRST};
            3'd5:    w = '{OP_APPLY,  A_GROWTH, B_INIT,   C_NEXT,     STEP_FIRST};
            3'd6:    w = '{OP_CLAMP,  A_GROWTH, B_INIT,   C_NEXT,     STEP_FIRST};
            3'd7:    w = '{OP_OUT,    A_GROWTH, B_INIT,   C_FINISH,   STEP_FIRST};
            default: w = '{OP_OUT,    A_GROWTH, B_INIT,   C_FINISH,   STEP_FIRST};
        endcase
        return w;
    endfunction

endpackage

@@ sv/rbc_item_if.sv @@
`timescale 1ns / 1ps

interface rbc_item_if;
    logic                          valid;
    logic                          ready;
    logic [rbc_pkg::MODE_W-1:0]    mode;
    logic                          success;
    logic                          retryable;
    logic [rbc_pkg::TIME_W-1:0]    elapsed_ms;
    logic [rbc_pkg::RAND_W-1:0]    random_value;

    modport source (
        output valid, mode, success, retryable, elapsed_ms, random_value,
        input  ready
    );
    modport sink (
        input  valid, mode, success, retryable, elapsed_ms, random_value,
        output ready
    );
endinterface

@@ sv/rbc_result_if.sv @@
`timescale 1ns / 1ps

interface rbc_result_if;
    logic                            valid;
    logic                            ready;
    logic [rbc_pkg::STATUS_W-1:0]    status;
    logic [rbc_pkg::ATT_OUT_W-1:0]   attempt;
    logic [rbc_pkg::TIME_W-1:0]      delay_ms;
    logic                            running;

    modport source (
        output valid, status, attempt, delay_ms, running,
        input  ready
    );
    modport sink (
        input  valid, status, attempt, delay_ms, running,
        output ready
    );
endinterface

@@ sv/retry_backoff_controller.sv @@
`timescale 1ns / 1ps

// Retry controller with exponential, linear, Fibonacci or no backoff and signed jitter.
// One item in, one result out. Items are processed one at a time by a small
// microcoded sequencer around a single shared 48x17 multiplier: an item that
// does not schedule a retry takes the decide step and then the result load; a
// scheduled retry takes decide, base, growth, term, magnitude, apply, clamp and
// result load (term, magnitude and apply are skipped when jitter_factor is
// zero), as the base delay, the growth-factor update and the two jitter products
// each need one pass through the multiplier. Ready returns the cycle after the
// result is loaded. The next item is accepted as soon as the sequencer is idle,
// even while the previous result waits in the output register; a result that is
// not taken holds the sequencer at its last step.
// Configuration writes must only be issued while no item is in flight.
module retry_backoff_controller #(
    parameter int DELAY_BITS   = rbc_pkg::DELAY_BITS_DEF,
    parameter int ATTEMPT_BITS = rbc_pkg::ATTEMPT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    rbc_item_if.sink                          item,
    rbc_result_if.source                      result
);

    localparam int CmpW = (ATTEMPT_BITS > 8) ? ATTEMPT_BITS : 8;
    localparam logic [ATTEMPT_BITS-1:0] CntMax = {ATTEMPT_BITS{1'b1}};
    localparam logic [rbc_pkg::BASE_W-1:0] DelayMax =
        rbc_pkg::BASE_W'((64'd1 << DELAY_BITS) - 64'd1);

    // Configuration
    rbc_pkg::policy_t  policy_reg, policy_next;
    logic [15:0]       init_delay_reg, init_delay_next;
    logic [15:0]       mult_reg, mult_next;
    logic [7:0]        max_att_reg, max_att_next;
    logic [23:0]       max_delay_reg, max_delay_next;
    logic [23:0]       timeout_reg, timeout_next;
    logic [15:0]       jitter_reg, jitter_next;

    // Controller state
    logic [ATTEMPT_BITS-1:0]          attempt_count_reg, attempt_count_next;
    logic                             running_reg, running_next;
    logic                             cancelled_reg, cancelled_next;
    logic [rbc_pkg::GROWTH_W-1:0]     growth_reg, growth_next;
    logic [rbc_pkg::FIB_W-1:0]        fib_prev_reg, fib_prev_next;
    logic [rbc_pkg::FIB_W-1:0]        fib_cur_reg, fib_cur_next;

    // Sequencer
    logic                             busy_reg, busy_next;
    logic [rbc_pkg::STEP_W-1:0]       step_reg, step_next;
    rbc_pkg::ucode_t                  uc;

    // Latched item
    rbc_pkg::mode_t                   mode_reg, mode_next;
    logic                             success_reg, success_next;
    logic                             retryable_reg, retryable_next;
    logic [rbc_pkg::TIME_W-1:0]       elapsed_reg, elapsed_next;
    logic [rbc_pkg::RAND_W-1:0]       rnd_reg, rnd_next;

    // Datapath
    logic [rbc_pkg::BASE_W-1:0]       base_reg, base_next;
    logic [rbc_pkg::TERM_W-1:0]       term_reg, term_next;
    logic [rbc_pkg::MAG_W-1:0]        mag_reg, mag_next;
    rbc_pkg::status_t                 status_reg, status_next;
    logic [rbc_pkg::TIME_W-1:0]       delay_reg, delay_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    rbc_pkg::status_t                 out_status_reg, out_status_next;
    logic [rbc_pkg::ATT_OUT_W-1:0]    out_attempt_reg, out_attempt_next;
    logic [rbc_pkg::TIME_W-1:0]       out_delay_reg, out_delay_next;
    logic                             out_running_reg, out_running_next;

    logic                             item_acc;
    logic                             out_free;
    logic [rbc_pkg::MUL_A_W-1:0]      mul_a;
    logic [rbc_pkg::MUL_B_W-1:0]      mul_b;
    logic [rbc_pkg::PROD_W-1:0]       prod;
    logic [rbc_pkg::MUL_B_W-1:0]      twice;
    logic                             jit_up;
    logic [rbc_pkg::MUL_B_W-1:0]      jit_off;
    logic [ATTEMPT_BITS-1:0]          cnt_inc;
    logic [CmpW-1:0]                  cnt_inc_ext;
    logic [CmpW-1:0]                  max_att_ext;
    logic [CmpW-1:0]                  cnt_reg_ext;
    rbc_pkg::status_t                 dec_status;
    logic [ATTEMPT_BITS-1:0]          dec_count;
    logic                             dec_running;
    logic                             dec_cancelled;
    logic                             dec_clear;
    logic [rbc_pkg::FIB_W:0]          fib_sum;
    logic [rbc_pkg::BASE_W-1:0]       jit_hi;
    logic [rbc_pkg::BASE_W-1:0]       jit_dn;
    logic [rbc_pkg::BASE_W-1:0]       clamp_v;

    assign item_acc   = item.valid && item.ready;
    assign item.ready = !busy_reg;
    assign out_free   = !out_valid_reg || result.ready;
    assign uc         = rbc_pkg::ucode(step_reg);

    assign result.valid    = out_valid_reg;
    assign result.status   = out_status_reg;
    assign result.attempt  = out_attempt_reg;
    assign result.delay_ms = out_delay_reg;
    assign result.running  = out_running_reg;

    // Jitter offset |2r - 1| in Q1.16
    assign twice   = {rnd_reg, 1'b0};
    assign jit_up  = rnd_reg[rbc_pkg::RAND_W-1];
    assign jit_off = jit_up ? (twice - rbc_pkg::RAND_ONE) : (rbc_pkg::RAND_ONE - twice);

    // Shared multiplier operand selection
    always_comb
    begin
        case (uc.a_sel)
            rbc_pkg::A_SCHED:
                mul_a = policy_reg[0] ? rbc_pkg::MUL_A_W'(fib_cur_reg)
                                      : rbc_pkg::MUL_A_W'(growth_reg);
            rbc_pkg::A_GROWTH: mul_a = rbc_pkg::MUL_A_W'(growth_reg);
            rbc_pkg::A_BASE:   mul_a = rbc_pkg::MUL_A_W'(base_reg);
            rbc_pkg::A_TERM:   mul_a = term_reg;
            default:           mul_a = '0;
        endcase
        case (uc.b_sel)
            rbc_pkg::B_INIT:   mul_b = rbc_pkg::MUL_B_W'(init_delay_reg);
            rbc_pkg::B_MULT:   mul_b = rbc_pkg::MUL_B_W'(mult_reg);
            rbc_pkg::B_JITTER: mul_b = rbc_pkg::MUL_B_W'(jitter_reg);
            rbc_pkg::B_OFFSET: mul_b = jit_off;
            default:           mul_b = '0;
        endcase
    end

    assign prod = rbc_pkg::PROD_W'(mul_a) * rbc_pkg::PROD_W'(mul_b);

    assign cnt_inc     = (attempt_count_reg == CntMax) ? attempt_count_reg
                                                       : attempt_count_reg + ATTEMPT_BITS'(1);
    assign cnt_inc_ext = CmpW'(cnt_inc);
    assign cnt_reg_ext = CmpW'(attempt_count_reg);
    assign max_att_ext = CmpW'(max_att_reg);
    assign fib_sum     = {1'b0, fib_prev_reg} + {1'b0, fib_cur_reg};
    assign jit_hi      = rbc_pkg::BASE_W'(mag_reg[rbc_pkg::MAG_W-1:32]);
    assign jit_dn      = jit_hi + rbc_pkg::BASE_W'(mag_reg[31:0] != 32'd0);
    assign clamp_v     = (base_reg > rbc_pkg::BASE_W'(max_delay_reg))
                         ? rbc_pkg::BASE_W'(max_delay_reg) : base_reg;

    // Outcome of the latched item
    always_comb
    begin
        dec_status    = rbc_pkg::ST_NONE;
        dec_count     = attempt_count_reg;
        dec_running   = running_reg;
        dec_cancelled = cancelled_reg;
        dec_clear     = 1'b0;
        case (mode_reg)
            rbc_pkg::MODE_RESET:
            begin
                dec_clear     = 1'b1;
                dec_running   = 1'b0;
                dec_cancelled = 1'b0;
            end
            rbc_pkg::MODE_START:
            begin
                dec_clear     = 1'b1;
                dec_running   = 1'b1;
                dec_cancelled = 1'b0;
            end
            rbc_pkg::MODE_CANCEL:
            begin
                dec_status    = rbc_pkg::ST_CANCELLED;
                dec_running   = 1'b0;
                dec_cancelled = 1'b1;
            end
            rbc_pkg::MODE_REPORT:
            begin
                if (cancelled_reg || !running_reg)
                begin
                    dec_status = rbc_pkg::ST_IGNORED;
                end
                else
                begin
                    dec_count = cnt_inc;
                    if (timeout_reg != '0 && elapsed_reg > timeout_reg)
                        dec_status = rbc_pkg::ST_TIMEOUT;
                    else if (cnt_inc_ext > max_att_ext)
                        dec_status = rbc_pkg::ST_MAX_ATT;
                    else if (success_reg)
                        dec_status = rbc_pkg::ST_SUCCESS;
                    else if (!retryable_reg)
                        dec_status = rbc_pkg::ST_NO_RETRY;
                    else if (cnt_inc_ext >= max_att_ext)
                        dec_status = rbc_pkg::ST_MAX_ATT;
                    else
                        dec_status = rbc_pkg::ST_RETRY;
                    if (dec_status != rbc_pkg::ST_RETRY)
                        dec_running = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        policy_next        = policy_reg;
        init_delay_next    = init_delay_reg;
        mult_next          = mult_reg;
        max_att_next       = max_att_reg;
        max_delay_next     = max_delay_reg;
        timeout_next       = timeout_reg;
        jitter_next        = jitter_reg;
        attempt_count_next = attempt_count_reg;
        running_next       = running_reg;
        cancelled_next     = cancelled_reg;
        growth_next        = growth_reg;
        fib_prev_next      = fib_prev_reg;
        fib_cur_next       = fib_cur_reg;
        busy_next          = busy_reg;
        step_next          = step_reg;
        mode_next          = mode_reg;
        success_next       = success_reg;
        retryable_next     = retryable_reg;
        elapsed_next       = elapsed_reg;
        rnd_next           = rnd_reg;
        base_next          = base_reg;
        term_next          = term_reg;
        mag_next           = mag_reg;
        status_next        = status_reg;
        delay_next         = delay_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        out_status_next    = out_status_reg;
        out_attempt_next   = out_attempt_reg;
        out_delay_next     = out_delay_reg;
        out_running_next   = out_running_reg;

        if (cfg_we)
        begin
            case (rbc_pkg::cfg_idx_t'(cfg_index))
                rbc_pkg::CFG_POLICY:     policy_next = rbc_pkg::policy_t'(cfg_wdata[1:0]);
                rbc_pkg::CFG_INIT_DELAY: init_delay_next = cfg_wdata[15:0];
                rbc_pkg::CFG_MULT:       mult_next = cfg_wdata[15:0];
                rbc_pkg::CFG_MAX_ATT:    max_att_next = cfg_wdata[7:0];
                rbc_pkg::CFG_MAX_DELAY:  max_delay_next = cfg_wdata[23:0];
                rbc_pkg::CFG_TIMEOUT:    timeout_next = cfg_wdata[23:0];
                rbc_pkg::CFG_JITTER:     jitter_next = cfg_wdata[15:0];
                default: ;
            endcase
        end

        if (!busy_reg)
        begin
            if (item_acc)
            begin
                busy_next      = 1'b1;
                step_next      = rbc_pkg::STEP_FIRST;
                mode_next      = rbc_pkg::mode_t'(item.mode);
                success_next   = item.success;
                retryable_next = item.retryable;
                elapsed_next   = item.elapsed_ms;
                rnd_next       = item.random_value;
            end
        end
        else
        begin
            case (uc.op)
                rbc_pkg::OP_DECIDE:
                begin
                    status_next        = dec_status;
                    delay_next         = '0;
                    running_next       = dec_running;
                    cancelled_next     = dec_cancelled;
                    attempt_count_next = dec_clear ? '0 : dec_count;
                    if (dec_clear)
                    begin
                        growth_next   = rbc_pkg::Q16_ONE;
                        fib_prev_next = rbc_pkg::FIB_ONE;
                        fib_cur_next  = rbc_pkg::FIB_ONE;
                    end
                end
                rbc_pkg::OP_BASE:
                begin
                    case (policy_reg)
                        rbc_pkg::POL_NONE:   base_next = '0;
                        rbc_pkg::POL_LINEAR: base_next = rbc_pkg::BASE_W'(init_delay_reg);
                        rbc_pkg::POL_EXP:    base_next = rbc_pkg::BASE_W'(prod[47:16]);
                        rbc_pkg::POL_FIB:
                            base_next = (prod[rbc_pkg::PROD_W-1:32] != '0)
                                        ? rbc_pkg::BASE_W'(32'hFFFF_FFFF)
                                        : rbc_pkg::BASE_W'(prod[31:0]);
                        default:             base_next = '0;
                    endcase
                end
                rbc_pkg::OP_GROWTH:
                begin
                    growth_next   = (prod[rbc_pkg::PROD_W-1:40] != '0) ? '1 : prod[39:8];
                    fib_prev_next = fib_cur_reg;
                    fib_cur_next  = fib_sum[rbc_pkg::FIB_W] ? '1 : fib_sum[rbc_pkg::FIB_W-1:0];
                end
                rbc_pkg::OP_TERM:  term_next = prod[rbc_pkg::TERM_W-1:0];
                rbc_pkg::OP_MAG:   mag_next = prod[rbc_pkg::MAG_W-1:0];
                rbc_pkg::OP_APPLY:
                begin
                    if (jit_up)
                        base_next = base_reg + jit_hi;
                    else
                        base_next = (jit_dn >= base_reg) ? '0 : base_reg - jit_dn;
                end
                rbc_pkg::OP_CLAMP:
                    delay_next = (clamp_v > DelayMax) ? DelayMax[rbc_pkg::TIME_W-1:0]
                                                      : clamp_v[rbc_pkg::TIME_W-1:0];
                rbc_pkg::OP_OUT: ;
                default: ;
            endcase

            case (uc.cond)
                rbc_pkg::C_NEXT: step_next = step_reg + 1'b1;
                rbc_pkg::C_NORETRY:
                    step_next = (dec_status != rbc_pkg::ST_RETRY) ? uc.target
                                                                  : step_reg + 1'b1;
                rbc_pkg::C_NOJITTER:
                    step_next = (jitter_reg == '0) ? uc.target : step_reg + 1'b1;
                rbc_pkg::C_FINISH:
                begin
                    // holds here until the output register has room
                    if (out_free)
                    begin
                        busy_next        = 1'b0;
                        out_valid_next   = 1'b1;
                        out_status_next  = status_reg;
                        out_attempt_next = cnt_reg_ext[rbc_pkg::ATT_OUT_W-1:0];
                        out_delay_next   = delay_reg;
                        out_running_next = running_reg;
                    end
                end
                default: step_next = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg        <= rbc_pkg::policy_t'(rbc_pkg::POLICY_RST);
            init_delay_reg    <= rbc_pkg::INIT_DELAY_RST;
            mult_reg          <= rbc_pkg::MULT_RST;
            max_att_reg       <= rbc_pkg::MAX_ATT_RST;
            max_delay_reg     <= rbc_pkg::MAX_DELAY_RST;
            timeout_reg       <= rbc_pkg::TIMEOUT_RST;
            jitter_reg        <= rbc_pkg::JITTER_RST;
            attempt_count_reg <= '0;
            running_reg       <= 1'b0;
            cancelled_reg     <= 1'b0;
            growth_reg        <= rbc_pkg::Q16_ONE;
            fib_prev_reg      <= rbc_pkg::FIB_ONE;
            fib_cur_reg       <= rbc_pkg::FIB_ONE;
            busy_reg          <= 1'b0;
            step_reg          <= rbc_pkg::STEP_FIRST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            policy_reg        <= policy_next;
            init_delay_reg    <= init_delay_next;
            mult_reg          <= mult_next;
            max_att_reg       <= max_att_next;
            max_delay_reg     <= max_delay_next;
            timeout_reg       <= timeout_next;
            jitter_reg        <= jitter_next;
            attempt_count_reg <= attempt_count_next;
            running_reg       <= running_next;
            cancelled_reg     <= cancelled_next;
            growth_reg        <= growth_next;
            fib_prev_reg      <= fib_prev_next;
            fib_cur_reg       <= fib_cur_next;
            busy_reg          <= busy_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        success_reg     <= success_next;
        retryable_reg   <= retryable_next;
        elapsed_reg     <= elapsed_next;
        rnd_reg         <= rnd_next;
        base_reg        <= base_next;
        term_reg        <= term_next;
        mag_reg         <= mag_next;
        status_reg      <= status_next;
        delay_reg       <= delay_next;
        out_status_reg  <= out_status_next;
        out_attempt_reg <= out_attempt_next;
        out_delay_reg   <= out_delay_next;
        out_running_reg <= out_running_next;
    end

    // A scheduled retry always leaves the run active
    a_retry_running: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == rbc_pkg::ST_RETRY |-> result.running)
        else $error("retry result with run not active");

    // Only a scheduled retry carries a delay
    a_delay_only_retry: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status != rbc_pkg::ST_RETRY |-> result.delay_ms == '0)
        else $error("delay on a non-retry result");

    // Delay never exceeds the clamp
    a_delay_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.delay_ms <= max_delay_reg)
        else $error("delay above max_delay_ms");

    // An accepted item starts the program at its first step
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> busy_reg && step_reg == rbc_pkg::STEP_FIRST)
        else $error("sequencer did not start on accepted item");

endmodule

@@ bench/tb_retry_backoff_controller.sv @@
`timescale 1ns / 1ps

module tb_retry_backoff_controller;

    localparam int LIMIT_CYCLES = 200000;
    localparam logic [rbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [rbc_pkg::ATT_OUT_W-1:0] ATT_SAT = 8'hFF;
    localparam logic [63:0] U32_SAT = 64'hFFFF_FFFF;
    localparam logic [63:0] FIB_SAT = 64'hFF_FFFF;
    localparam logic [63:0] RAND_SCALE = 64'h1_0000;

    typedef struct packed {
        rbc_pkg::status_t                 status;
        logic [rbc_pkg::ATT_OUT_W-1:0]    attempt;
        logic [rbc_pkg::TIME_W-1:0]       delay_ms;
        logic                             running;
    } decision_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [rbc_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [rbc_pkg::CFG_DATA_W-1:0]   cfg_wdata;

    rbc_item_if   item_ch();
    rbc_result_if result_ch();

    retry_backoff_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // register shadow
    rbc_pkg::policy_t  pol_r;
    logic [15:0]       init_r;
    logic [15:0]       mult_r;
    logic [7:0]        maxatt_r;
    logic [23:0]       maxdly_r;
    logic [23:0]       tmo_r;
    logic [15:0]       jit_r;

    // controller state
    logic [rbc_pkg::ATT_OUT_W-1:0]  tries;
    logic                           active;
    logic                           aborted;
    logic [rbc_pkg::GROWTH_W-1:0]   growth;
    logic [rbc_pkg::FIB_W-1:0]      fib_prev;
    logic [rbc_pkg::FIB_W-1:0]      fib_cur;

    decision_t decision_q[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  hold_left = 0;
    bit  gaps_on = 1'b1;
    bit  stalls_on = 1'b1;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_retry_backoff_controller failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            result_ch.ready <= !stalls_on || ($urandom_range(0, 99) >= 7);
    end

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic rnd_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [rbc_pkg::TIME_W-1:0] rnd_time();
        return rbc_pkg::TIME_W'($urandom());
    endfunction

    function automatic logic [rbc_pkg::RAND_W-1:0] rnd_value();
        return rbc_pkg::RAND_W'($urandom());
    endfunction

    function automatic void clear_progress();
        tries = '0;
        growth = rbc_pkg::Q16_ONE;
        fib_prev = rbc_pkg::FIB_ONE;
        fib_cur = rbc_pkg::FIB_ONE;
    endfunction

    function automatic logic [rbc_pkg::TIME_W-1:0] backoff_delay(
            logic [rbc_pkg::RAND_W-1:0] rv);
        logic [63:0] base;
        logic [63:0] scale;
        logic [63:0] rnd2;
        logic [63:0] off;
        logic [63:0] mag;
        logic [63:0] dn;
        logic        up;
        scale = 64'(init_r);
        case (pol_r)
            rbc_pkg::POL_NONE:   base = '0;
            rbc_pkg::POL_LINEAR: base = scale;
            rbc_pkg::POL_EXP:    base = (scale * 64'(growth)) >> 16;
            default:             base = scale * 64'(fib_cur);
        endcase
        if (base > U32_SAT)
            base = U32_SAT;
        if (jit_r != '0)
        begin
            // signed jitter: (2r - 1) * base * jitter, kept as magnitude and sign
            rnd2 = 64'(rv);
            rnd2 = rnd2 << 1;
            up = (rnd2 >= RAND_SCALE);
            off = up ? rnd2 - RAND_SCALE : RAND_SCALE - rnd2;
            mag = base * 64'(jit_r) * off;
            if (up)
                base = base + (mag >> 32);
            else
            begin
                dn = (mag >> 32) + 64'(mag[31:0] != 32'd0);
                base = (dn >= base) ? 64'd0 : base - dn;
            end
        end
        if (base > 64'(maxdly_r))
            base = 64'(maxdly_r);
        return base[rbc_pkg::TIME_W-1:0];
    endfunction

    function automatic decision_t retry_decision(rbc_pkg::mode_t m, logic ok, logic rt,
            logic [rbc_pkg::TIME_W-1:0] el, logic [rbc_pkg::RAND_W-1:0] rv);
        decision_t  d;
        logic [63:0] g;
        logic [63:0] f;
        d.status = rbc_pkg::ST_NONE;
        d.delay_ms = '0;
        case (m)
            rbc_pkg::MODE_RESET:
            begin
                clear_progress();
                active = 1'b0;
                aborted = 1'b0;
            end
            rbc_pkg::MODE_START:
            begin
                clear_progress();
                active = 1'b1;
                aborted = 1'b0;
            end
            rbc_pkg::MODE_CANCEL:
            begin
                aborted = 1'b1;
                active = 1'b0;
                d.status = rbc_pkg::ST_CANCELLED;
            end
            default:
            begin
                if (aborted || !active)
                    d.status = rbc_pkg::ST_IGNORED;
                else
                begin
                    if (tries != ATT_SAT)
                        tries = tries + 1'b1;
                    if (tmo_r != '0 && el > tmo_r)
                        d.status = rbc_pkg::ST_TIMEOUT;
                    else if (tries > maxatt_r)
                        d.status = rbc_pkg::ST_MAX_ATT;
                    else if (ok)
                        d.status = rbc_pkg::ST_SUCCESS;
                    else if (!rt)
                        d.status = rbc_pkg::ST_NO_RETRY;
                    else if (tries >= maxatt_r)
                        d.status = rbc_pkg::ST_MAX_ATT;
                    else
                    begin
                        d.status = rbc_pkg::ST_RETRY;
                        d.delay_ms = backoff_delay(rv);
                        g = 64'(growth);
                        g = (g * 64'(mult_r)) >> 8;
                        f = 64'(fib_prev);
                        f = f + 64'(fib_cur);
                        growth = (g > U32_SAT) ? '1 : g[rbc_pkg::GROWTH_W-1:0];
                        fib_prev = fib_cur;
                        fib_cur = (f > FIB_SAT) ? '1 : f[rbc_pkg::FIB_W-1:0];
                    end
                    if (d.status != rbc_pkg::ST_RETRY)
                        active = 1'b0;
                end
            end
        endcase
        d.attempt = tries;
        d.running = active;
        return d;
    endfunction

    function automatic logic [31:0] config_value(int width);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (32'd1 << width) - 32'd1;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       v = v | mask;
            1:       v = v & ~mask;
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(logic [rbc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[rbc_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            rbc_pkg::CFG_POLICY:     pol_r = rbc_pkg::policy_t'(data[rbc_pkg::POLICY_W-1:0]);
            rbc_pkg::CFG_INIT_DELAY: init_r = data[15:0];
            rbc_pkg::CFG_MULT:       mult_r = data[15:0];
            rbc_pkg::CFG_MAX_ATT:    maxatt_r = data[7:0];
            rbc_pkg::CFG_MAX_DELAY:  maxdly_r = data[23:0];
            rbc_pkg::CFG_TIMEOUT:    tmo_r = data[23:0];
            rbc_pkg::CFG_JITTER:     jit_r = data[15:0];
            default:                 ;
        endcase
    endtask

    // enters just after a rising edge, returns at the edge that accepts the item
    task automatic send_item(rbc_pkg::mode_t m, logic ok, logic rt,
            logic [rbc_pkg::TIME_W-1:0] el, logic [rbc_pkg::RAND_W-1:0] rv);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 7)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.mode <= m;
        item_ch.success <= ok;
        item_ch.retryable <= rt;
        item_ch.elapsed_ms <= el;
        item_ch.random_value <= rv;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        decision_q.insert(decision_q.size(), retry_decision(m, ok, rt, el, rv));
        items_sent++;
    endtask

    task automatic send_report(logic ok, logic rt, logic [rbc_pkg::TIME_W-1:0] el,
            logic [rbc_pkg::RAND_W-1:0] rv);
        send_item(rbc_pkg::MODE_REPORT, ok, rt, el, rv);
    endtask

    // non-report items still carry random payload bits
    task automatic send_control(rbc_pkg::mode_t m);
        send_item(m, rnd_bit(), rnd_bit(), rnd_time(), rnd_value());
    endtask

    task automatic drain();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (decision_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic run_sequence();
        logic [rbc_pkg::TIME_W-1:0] el;
        int pick;
        el = '0;
        if (coin(90))
            send_control(rbc_pkg::MODE_START);
        repeat ($urandom_range(1, 8))
        begin
            pick = $urandom_range(0, 99);
            if (coin(10))
                el = rnd_time();
            else
                el = el + rbc_pkg::TIME_W'($urandom_range(0, 3000));
            if (pick < 80)
                send_report(1'b0, 1'b1, el, rnd_value());
            else if (pick < 88)
                send_report(1'b1, rnd_bit(), el, rnd_value());
            else if (pick < 93)
                send_report(1'b0, 1'b0, el, rnd_value());
            else if (pick < 96)
                send_control(rbc_pkg::MODE_CANCEL);
            else if (pick < 98)
                send_control(rbc_pkg::MODE_RESET);
            else
                send_control(rbc_pkg::MODE_START);
        end
    endtask

    task automatic test_reset_defaults();
        send_control(rbc_pkg::MODE_START);
        repeat (3) send_report(1'b0, 1'b1, '0, rnd_value());
    endtask

    task automatic test_special_cases();
        drain();
        write_reg(rbc_pkg::CFG_POLICY, 32'(rbc_pkg::POL_LINEAR));
        write_reg(CFG_UNUSED, 32'hFF_FFFF);
        send_control(rbc_pkg::MODE_CANCEL);
        send_report(1'b1, 1'b1, 24'd5, rnd_value());
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b1, 24'd10, rnd_value());
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b1, 24'd20, rnd_value());
        send_control(rbc_pkg::MODE_RESET);
        send_report(1'b0, 1'b1, 24'd30, rnd_value());
        send_control(rbc_pkg::MODE_START);
        send_report(1'b1, 1'b0, 24'd40, rnd_value());
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b0, 24'd50, rnd_value());
        drain();
        write_reg(rbc_pkg::CFG_TIMEOUT, 32'd100);
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b1, 24'd100, rnd_value());
        send_report(1'b0, 1'b1, 24'd101, rnd_value());
        drain();
        write_reg(rbc_pkg::CFG_TIMEOUT, 32'd0);
        write_reg(rbc_pkg::CFG_MAX_ATT, 32'd0);
        send_control(rbc_pkg::MODE_START);
        send_report(1'b1, 1'b1, 24'd0, rnd_value());
    endtask

    task automatic test_jitter_edges();
        drain();
        write_reg(rbc_pkg::CFG_POLICY, 32'(rbc_pkg::POL_FIB));
        write_reg(rbc_pkg::CFG_INIT_DELAY, 32'hFFFF);
        write_reg(rbc_pkg::CFG_MAX_ATT, 32'd20);
        write_reg(rbc_pkg::CFG_MAX_DELAY, 32'hFF_FFFF);
        write_reg(rbc_pkg::CFG_JITTER, 32'hFFFF);
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b1, 24'd0, 16'h0000);
        send_report(1'b0, 1'b1, 24'd0, 16'h8000);
        send_report(1'b0, 1'b1, 24'd0, 16'hFFFF);
        drain();
        write_reg(rbc_pkg::CFG_POLICY, 32'(rbc_pkg::POL_NONE));
        send_control(rbc_pkg::MODE_START);
        send_report(1'b0, 1'b1, 24'd0, 16'hFFFF);
    endtask

    // full-length run with no idling: fib and the clamp saturate on the way
    task automatic test_long_run();
        logic [rbc_pkg::TIME_W-1:0] el;
        drain();
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        write_reg(rbc_pkg::CFG_POLICY, 32'(rbc_pkg::POL_FIB));
        write_reg(rbc_pkg::CFG_MAX_ATT, 32'hFF);
        write_reg(rbc_pkg::CFG_JITTER, 32'h4000);
        el = '0;
        send_control(rbc_pkg::MODE_START);
        repeat (255)
        begin
            el = el + rbc_pkg::TIME_W'($urandom_range(0, 100));
            send_report(1'b0, 1'b1, el, rnd_value());
        end
        drain();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        drain();
        write_reg(rbc_pkg::CFG_POLICY, 32'(rbc_pkg::POL_EXP));
        write_reg(rbc_pkg::CFG_MULT, 32'hFFFF);
        write_reg(rbc_pkg::CFG_INIT_DELAY, 32'd1);
        write_reg(rbc_pkg::CFG_MAX_ATT, 32'd40);
        write_reg(rbc_pkg::CFG_JITTER, 32'd0);
        send_control(rbc_pkg::MODE_START);
        hold_left = 400;
        repeat (30)
            send_report(1'b0, 1'b1, rbc_pkg::TIME_W'($urandom_range(0, 1000)), rnd_value());
    endtask

    task automatic test_random_phases();
        int target;
        repeat (9)
        begin
            // registers change between phases; an open run carries over
            drain();
            write_reg(rbc_pkg::CFG_POLICY, config_value(rbc_pkg::POLICY_W));
            write_reg(rbc_pkg::CFG_INIT_DELAY,
                      coin(50) ? $urandom_range(1, 5000) : config_value(16));
            write_reg(rbc_pkg::CFG_MULT,
                      coin(60) ? $urandom_range(256, 1024) : config_value(16));
            write_reg(rbc_pkg::CFG_MAX_ATT,
                      coin(70) ? $urandom_range(1, 8) : config_value(8));
            write_reg(rbc_pkg::CFG_MAX_DELAY,
                      coin(40) ? $urandom_range(1000, 100000) : config_value(24));
            write_reg(rbc_pkg::CFG_TIMEOUT, coin(50) ? 32'd0 :
                      (coin(50) ? $urandom_range(1, 30000) : config_value(24)));
            write_reg(rbc_pkg::CFG_JITTER, coin(40) ? 32'd0 : config_value(16));
            if (coin(20))
                write_reg(CFG_UNUSED, $urandom());
            target = items_sent + 34;
            while (items_sent < target)
            begin
                if (coin(85))
                    run_sequence();
                else
                    send_item(rbc_pkg::mode_t'($urandom_range(0, 3)), rnd_bit(),
                              rnd_bit(), rnd_time(), rnd_value());
            end
        end
    endtask

    initial
    begin : result_check
        decision_t got;
        decision_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                got.status = rbc_pkg::status_t'(result_ch.status);
                got.attempt = result_ch.attempt;
                got.delay_ms = result_ch.delay_ms;
                got.running = result_ch.running;
                // compare after the edge so every accepted item is predicted
                @(negedge clk);
                if (decision_q.size() == 0)
                begin
                    $error("unexpected result: status %0d attempt %0d", got.status,
                           got.attempt);
                    mismatches++;
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.attempt != want.attempt)
                    begin
                        $error("attempt: expected %0d, got %0d", want.attempt, got.attempt);
                        mismatches++;
                    end
                    if (got.delay_ms != want.delay_ms)
                    begin
                        $error("delay_ms: expected %0d, got %0d", want.delay_ms,
                               got.delay_ms);
                        mismatches++;
                    end
                    if (got.running != want.running)
                    begin
                        $error("running: expected %0d, got %0d", want.running, got.running);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.mode = rbc_pkg::MODE_RESET;
        item_ch.success = 1'b0;
        item_ch.retryable = 1'b0;
        item_ch.elapsed_ms = '0;
        item_ch.random_value = '0;
        result_ch.ready = 1'b0;

        pol_r = rbc_pkg::policy_t'(rbc_pkg::POLICY_RST);
        init_r = rbc_pkg::INIT_DELAY_RST;
        mult_r = rbc_pkg::MULT_RST;
        maxatt_r = rbc_pkg::MAX_ATT_RST;
        maxdly_r = rbc_pkg::MAX_DELAY_RST;
        tmo_r = rbc_pkg::TIMEOUT_RST;
        jit_r = rbc_pkg::JITTER_RST;
        clear_progress();
        active = 1'b0;
        aborted = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_jitter_edges();
        test_long_run();
        test_backpressure();
        test_random_phases();
        drain();

        if (mismatches == 0)
            $display("tb_retry_backoff_controller passed");
        else
            $display("tb_retry_backoff_controller failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/rbc_pkg.sv
sv/rbc_item_if.sv
sv/rbc_result_if.sv
sv/retry_backoff_controller.sv
bench/tb_retry_backoff_controller.sv
